// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kpv_pkg.sv
// Package for the position/velocity Kalman step: word format constants,
// register indexes, ALU operation codes and the sequencer's control struct.
`default_nettype none
package kpv_pkg;
  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int ExtBits  = WordBits + 2;

  localparam logic [1:0] CFG_TIME_STEP     = 2'd0;
  localparam logic [1:0] CFG_MEASURE_NOISE = 2'd1;
  localparam logic [1:0] CFG_PROCESS_NOISE = 2'd2;

  localparam logic signed [WordBits-1:0] WordMax = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] WordMin = {1'b1, {(WordBits-1){1'b0}}};

  typedef logic signed [WordBits-1:0] word_t;

  // ALU operations
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_HALF = 3'd4
  } alu_op_t;

  // Register file slots
  typedef enum logic [4:0] {
    R_POS, R_VEL, R_P00, R_P01, R_P10, R_P11, R_ACC, R_Z, R_DT, R_RN, R_QN,
    R_T0, R_T1, R_HDT2, R_X0, R_X1, R_RES, R_S, R_T00, R_T01, R_K0, R_K1,
    R_A00, R_A10, R_U00, R_N00, R_N01, R_N10, R_N11, R_T2
  } reg_sel_t;

  // Request from sequencer to the ALU
  typedef struct packed {
    logic    start;
    alu_op_t op;
    word_t   a;
    word_t   b;
  } alu_req_t;

  typedef struct packed {
    logic  done;
    word_t res;
    logic  sat;
  } alu_rsp_t;

  // Saturate a wide signed value to the word range.
  function automatic word_t sat_word(input logic signed [ExtBits-1:0] v, output logic s);
    begin
      s = 1'b0;
      if (v > ExtBits'(WordMax)) begin
        s = 1'b1;
        sat_word = WordMax;
      end else if (v < ExtBits'(WordMin)) begin
        s = 1'b1;
        sat_word = WordMin;
      end else begin
        sat_word = v[WordBits-1:0];
      end
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/kalman_position_velocity_step_top.sv
// Top level of the position/velocity Kalman step: stream ports, config
// registers and output register. Depends on kpv_pkg, kpv_alu, kpv_seq.
//
// Channel | Direction | Content
// in_     | slave     | tdata = accel[31:0], position_meas[63:32]
// out_    | master    | tdata = position_est[31:0], velocity_est[63:32]; tuser = saturated
// cfg_    | slave     | index 0 time_step, 1 measure_noise, 2 process_noise
//
// One item takes 36 ALU operations on the shared ALU, two of them divides
// by S. in_tready is low while an item is in work or its result still
// waits, so a new item is not taken before the last result has gone.
// Reset clears state and covariance.
`default_nettype none
module kalman_position_velocity_step_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // accel, position_meas
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // position_est, velocity_est
  output logic             out_tuser,  // saturated
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [15:0] dt_r;
  logic [30:0] rn_r, qn_r;
  logic busy_r, ov_r;
  logic [63:0] od_r;
  logic ou_r;
  kpv_pkg::alu_req_t req;
  kpv_pkg::alu_rsp_t rsp;
  logic done, sat;
  kpv_pkg::word_t pos, vel;
  logic acc_in;

  assign acc_in    = in_tvalid && in_tready;
  assign in_tready = !busy_r && !ov_r;
  assign cfg_ready = 1'b1;

  kpv_alu u_alu (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  kpv_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(acc_in),
    .acc_in(in_tdata[31:0]), .z_in(in_tdata[63:32]),
    .time_step(dt_r), .measure_noise(rn_r), .process_noise(qn_r),
    .rsp(rsp), .req(req), .done(done), .pos_o(pos), .vel_o(vel), .sat_o(sat)
  );

  // config, busy and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= 16'd328; rn_r <= 31'd196608; qn_r <= 31'd458752;
      busy_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          kpv_pkg::CFG_TIME_STEP:     dt_r <= cfg_data[15:0];
          kpv_pkg::CFG_MEASURE_NOISE: rn_r <= cfg_data[30:0];
          kpv_pkg::CFG_PROCESS_NOISE: qn_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (acc_in) busy_r <= 1'b1;
      else if (done) busy_r <= 1'b0;
      if (done) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (done) begin
      od_r <= {vel, pos};
      ou_r <= sat;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
endmodule
`default_nettype wire

// File: rtl/kpv_alu.sv
// Shared arithmetic unit: saturating add/sub/half, floored product,
// restoring divide one quotient bit per cycle.
// Depends on kpv_pkg.
`default_nettype none
module kpv_alu (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire kpv_pkg::alu_req_t req,
  output kpv_pkg::alu_rsp_t      rsp
);
  localparam int W   = kpv_pkg::WordBits;
  localparam int F   = kpv_pkg::FracBits;
  localparam int QB  = W + F;              // quotient bits worth computing
  localparam int CW  = $clog2(QB + 1);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } ast_t;

  ast_t ast_r, ast_nxt;
  logic [W-1:0]     bm_r, bm_nxt;
  logic             neg_r, neg_nxt;
  logic [2*W-1:0]   prod_r, prod_nxt;
  logic [QB-1:0]    num_r, num_nxt, quo_r, quo_nxt;
  logic [W:0]       rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             done_r, done_nxt, sat_r, sat_nxt;
  kpv_pkg::word_t   res_r, res_nxt;

  logic [W-1:0]     amag, bmag;
  logic signed [kpv_pkg::ExtBits-1:0] ext;
  logic             s_fit;
  kpv_pkg::word_t   w_fit;
  logic [W:0]       rsh;
  logic [2*W:0]     rnd;
  logic [2*W-F:0]   shf;
  logic [W:0]       lim;
  logic [QB:0]      mag;

  assign amag = req.a[W-1] ? W'(-req.a) : W'(req.a);
  assign bmag = req.b[W-1] ? W'(-req.b) : W'(req.b);
  assign rsh  = {rem_r[W-1:0], num_r[QB-1]};
  assign rnd  = {1'b0, prod_r} + (neg_r ? (2*W+1)'((1 << F) - 1) : '0);
  assign shf  = rnd[2*W:F];
  assign lim  = neg_r ? {1'b1, {W{1'b0}}} >> 1 : {2'b00, {(W-1){1'b1}}};
  assign mag  = (ast_r == A_MUL) ? (QB+1)'(shf) : {1'b0, quo_r};

  always_comb begin
    ast_nxt = ast_r; bm_nxt = bm_r; neg_nxt = neg_r;
    prod_nxt = prod_r; num_nxt = num_r; quo_nxt = quo_r; rem_nxt = rem_r;
    cnt_nxt = cnt_r; done_nxt = 1'b0; sat_nxt = sat_r; res_nxt = res_r;
    ext = '0; s_fit = 1'b0; w_fit = '0;
    case (ast_r)
      A_IDLE: begin
        if (req.start) begin
          bm_nxt  = bmag;
          neg_nxt = req.a[W-1] ^ req.b[W-1];
          case (req.op)
            kpv_pkg::OP_ADD, kpv_pkg::OP_SUB, kpv_pkg::OP_HALF: begin
              if (req.op == kpv_pkg::OP_ADD)
                ext = kpv_pkg::ExtBits'(req.a) + kpv_pkg::ExtBits'(req.b);
              else if (req.op == kpv_pkg::OP_SUB)
                ext = kpv_pkg::ExtBits'(req.a) - kpv_pkg::ExtBits'(req.b);
              else  // truncating halve of a nonnegative or negative word
                ext = kpv_pkg::ExtBits'($signed(req.a + W'(req.a[W-1])) >>> 1);
              w_fit    = kpv_pkg::sat_word(ext, s_fit);
              res_nxt  = w_fit;
              sat_nxt  = s_fit;
              done_nxt = 1'b1;
            end
            kpv_pkg::OP_MUL: begin
              prod_nxt = amag * bmag;
              ast_nxt  = A_MUL;
            end
            kpv_pkg::OP_DIV: begin
              if (req.b == '0) begin
                res_nxt  = (req.a == '0) ? '0 : (req.a[W-1] ? kpv_pkg::WordMin
                                                          : kpv_pkg::WordMax);
                sat_nxt  = (req.a != '0);
                done_nxt = 1'b1;
              end else begin
                num_nxt = {amag, {F{1'b0}}};
                quo_nxt = '0;
                rem_nxt = '0;
                cnt_nxt = CW'(QB);
                ast_nxt = A_DIV;
              end
            end
            default: begin
              res_nxt  = '0;
              sat_nxt  = 1'b0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end
      A_MUL: ast_nxt = A_FIN;
      A_DIV: begin
        // one restoring step per cycle
        num_nxt = num_r << 1;
        if (rsh >= {1'b0, bm_r}) begin
          rem_nxt = rsh - {1'b0, bm_r};
          quo_nxt = {quo_r[QB-2:0], 1'b1};
        end else begin
          rem_nxt = rsh;
          quo_nxt = {quo_r[QB-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) ast_nxt = A_FIN;
      end
      A_FIN: ast_nxt = A_IDLE;
      default: ast_nxt = A_IDLE;
    endcase
    // shared fit to word range with sign
    if (ast_r == A_FIN) begin
      if (mag > (QB+1)'(lim)) begin
        sat_nxt = 1'b1;
        res_nxt = neg_r ? kpv_pkg::WordMin : kpv_pkg::WordMax;
      end else begin
        sat_nxt = 1'b0;
        res_nxt = neg_r ? W'(-mag[W-1:0]) : mag[W-1:0];
      end
      done_nxt = 1'b1;
    end
  end

  // A_FIN always reads quo_r; for products it holds the latched, clamped shf
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ast_r  <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      ast_r  <= (ast_r == A_MUL) ? A_FIN : ast_nxt;
      done_r <= done_nxt;
    end
    bm_r <= bm_nxt; neg_r <= neg_nxt; num_r <= num_nxt;
    rem_r <= rem_nxt; cnt_r <= cnt_nxt; sat_r <= sat_nxt; res_r <= res_nxt;
    prod_r <= prod_nxt;
    // latch shifted product as the magnitude source for the fit stage
    quo_r  <= (ast_r == A_MUL) ? QB'(shf > (2*W-F+1)'({QB{1'b1}}) ? {QB{1'b1}} : shf)
                               : quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
  assign rsp.sat  = sat_r;
endmodule
`default_nettype wire

// File: rtl/kpv_seq.sv
// Step sequencer: holds state, registers and temporaries, and issues the
// filter's operations to the shared ALU one after another.
// Depends on kpv_pkg.
`default_nettype none
module kpv_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire kpv_pkg::word_t    acc_in,
  input  wire kpv_pkg::word_t    z_in,
  input  wire logic [15:0]       time_step,
  input  wire logic [30:0]       measure_noise,
  input  wire logic [30:0]       process_noise,
  input  wire kpv_pkg::alu_rsp_t rsp,
  output kpv_pkg::alu_req_t      req,
  output logic                   done,
  output kpv_pkg::word_t         pos_o,
  output kpv_pkg::word_t         vel_o,
  output logic                   sat_o
);
  localparam int NOPS = 33;
  localparam int PW   = $clog2(NOPS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } st_t;

  typedef struct packed {
    kpv_pkg::alu_op_t  op;
    kpv_pkg::reg_sel_t a;
    kpv_pkg::reg_sel_t b;
    kpv_pkg::reg_sel_t d;
  } micro_t;

  st_t st_r, st_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  kpv_pkg::word_t rf_r [32];
  logic sat_r, sat_nxt;
  micro_t mi;

  // Program: order follows the filter step; temporaries feed later ops.
  // The last two steps add Q to N00, then to N11.
  always_comb begin
    case (pc_r)
      PW'(0):  mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_DT,   kpv_pkg::R_DT,  kpv_pkg::R_T0};
      PW'(1):  mi = '{kpv_pkg::OP_HALF, kpv_pkg::R_T0,   kpv_pkg::R_T0,  kpv_pkg::R_HDT2};
      PW'(2):  mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_DT,   kpv_pkg::R_VEL, kpv_pkg::R_T0};
      PW'(3):  mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_POS,  kpv_pkg::R_T0,  kpv_pkg::R_X0};
      PW'(4):  mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_HDT2, kpv_pkg::R_ACC, kpv_pkg::R_T0};
      PW'(5):  mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_X0,   kpv_pkg::R_T0,  kpv_pkg::R_X0};
      PW'(6):  mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_DT,   kpv_pkg::R_ACC, kpv_pkg::R_T0};
      PW'(7):  mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_VEL,  kpv_pkg::R_T0,  kpv_pkg::R_X1};
      PW'(8):  mi = '{kpv_pkg::OP_SUB,  kpv_pkg::R_Z,    kpv_pkg::R_X0,  kpv_pkg::R_RES};
      PW'(9):  mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_P00,  kpv_pkg::R_RN,  kpv_pkg::R_S};
      PW'(10): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_DT,   kpv_pkg::R_P10, kpv_pkg::R_T0};
      PW'(11): mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_P00,  kpv_pkg::R_T0,  kpv_pkg::R_T00};
      PW'(12): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_DT,   kpv_pkg::R_P11, kpv_pkg::R_T0};
      PW'(13): mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_P01,  kpv_pkg::R_T0,  kpv_pkg::R_T01};
      PW'(14): mi = '{kpv_pkg::OP_DIV,  kpv_pkg::R_T00,  kpv_pkg::R_S,   kpv_pkg::R_K0};
      PW'(15): mi = '{kpv_pkg::OP_DIV,  kpv_pkg::R_P10,  kpv_pkg::R_S,   kpv_pkg::R_K1};
      PW'(16): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_RES,  kpv_pkg::R_K0,  kpv_pkg::R_T0};
      PW'(17): mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_X0,   kpv_pkg::R_T0,  kpv_pkg::R_T1};
      PW'(18): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_RES,  kpv_pkg::R_K1,  kpv_pkg::R_T0};
      PW'(19): mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_X1,   kpv_pkg::R_T0,  kpv_pkg::R_T2};
      PW'(20): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_T01,  kpv_pkg::R_DT,  kpv_pkg::R_T0};
      PW'(21): mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_T00,  kpv_pkg::R_T0,  kpv_pkg::R_A00};
      PW'(22): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_P11,  kpv_pkg::R_DT,  kpv_pkg::R_T0};
      PW'(23): mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_P10,  kpv_pkg::R_T0,  kpv_pkg::R_A10};
      PW'(24): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_P01,  kpv_pkg::R_DT,  kpv_pkg::R_T0};
      PW'(25): mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_P00,  kpv_pkg::R_T0,  kpv_pkg::R_U00};
      PW'(26): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_K0,   kpv_pkg::R_U00, kpv_pkg::R_T0};
      PW'(27): mi = '{kpv_pkg::OP_SUB,  kpv_pkg::R_A00,  kpv_pkg::R_T0,  kpv_pkg::R_N00};
      PW'(28): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_K0,   kpv_pkg::R_P01, kpv_pkg::R_T0};
      PW'(29): mi = '{kpv_pkg::OP_SUB,  kpv_pkg::R_T01,  kpv_pkg::R_T0,  kpv_pkg::R_N01};
      PW'(30): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_K1,   kpv_pkg::R_U00, kpv_pkg::R_T0};
      PW'(31): mi = '{kpv_pkg::OP_SUB,  kpv_pkg::R_A10,  kpv_pkg::R_T0,  kpv_pkg::R_N10};
      PW'(32): mi = '{kpv_pkg::OP_MUL,  kpv_pkg::R_K1,   kpv_pkg::R_P01, kpv_pkg::R_T0};
      PW'(33): mi = '{kpv_pkg::OP_SUB,  kpv_pkg::R_P11,  kpv_pkg::R_T0,  kpv_pkg::R_N11};
      PW'(34): mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_N00,  kpv_pkg::R_QN,  kpv_pkg::R_N00};
      default: mi = '{kpv_pkg::OP_ADD,  kpv_pkg::R_N11,  kpv_pkg::R_QN,  kpv_pkg::R_N11};
    endcase
  end

  assign req.start = (st_r == S_ISSUE);
  assign req.op    = mi.op;
  assign req.a     = rf_r[mi.a];
  assign req.b     = rf_r[mi.b];

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; sat_nxt = sat_r;
    case (st_r)
      S_IDLE:  if (start) begin
        st_nxt = S_ISSUE; pc_nxt = '0; sat_nxt = 1'b0;
      end
      S_ISSUE: st_nxt = S_WAIT;
      S_WAIT:  if (rsp.done) begin
        sat_nxt = sat_r | rsp.sat;
        if (pc_r == PW'(NOPS + 2)) begin
          st_nxt = S_IDLE;
        end else begin
          pc_nxt = pc_r + 1'b1;
          st_nxt = S_ISSUE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      pc_r  <= '0;
      sat_r <= 1'b0;
      for (int i = 0; i < 32; i++) rf_r[i] <= '0;
    end else begin
      st_r  <= st_nxt;
      pc_r  <= pc_nxt;
      sat_r <= sat_nxt;
      if (st_r == S_IDLE && start) begin
        rf_r[kpv_pkg::R_ACC] <= acc_in;
        rf_r[kpv_pkg::R_Z]   <= z_in;
        rf_r[kpv_pkg::R_DT]  <= kpv_pkg::WordBits'(time_step);
        rf_r[kpv_pkg::R_RN]  <= kpv_pkg::WordBits'(measure_noise);
        rf_r[kpv_pkg::R_QN]  <= kpv_pkg::WordBits'(process_noise);
      end
      if (st_r == S_WAIT && rsp.done) begin
        rf_r[mi.d] <= rsp.res;
        if (pc_r == PW'(NOPS + 2)) begin
          // commit new state
          rf_r[kpv_pkg::R_POS] <= rf_r[kpv_pkg::R_T1];
          rf_r[kpv_pkg::R_VEL] <= rf_r[kpv_pkg::R_T2];
          rf_r[kpv_pkg::R_P00] <= rf_r[kpv_pkg::R_N00];
          rf_r[kpv_pkg::R_P01] <= rf_r[kpv_pkg::R_N01];
          rf_r[kpv_pkg::R_P10] <= rf_r[kpv_pkg::R_N10];
          rf_r[kpv_pkg::R_P11] <= rsp.res;
        end
      end
    end
  end

  assign done  = (st_r == S_WAIT) && rsp.done && (pc_r == PW'(NOPS + 2));
  assign pos_o = rf_r[kpv_pkg::R_T1];
  assign vel_o = rf_r[kpv_pkg::R_T2];
  assign sat_o = sat_r | rsp.sat;
endmodule
`default_nettype wire

// File: rtl/kpv_checker.sv
// Port-level checker for the Kalman step top level, with its bind.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module kpv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [63:0] out_tdata
);
  `CHK_NEXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accept")
  `CHK_IMPLY(a_no_in_while_out, clk, rst_n, out_tvalid, !in_tready, "input open with result pending")
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
endmodule

bind kalman_position_velocity_step_top kpv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// File: tb/kalman_position_velocity_step_top_tb.sv
// Testbench for the position/velocity Kalman step: drives items and register
// writes, predicts each estimate in fixed point and checks the output stream.
// Depends on kpv_pkg and kalman_position_velocity_step_top.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: own copy of filter state, registers and expected estimates.
class kalman_scoreboard;
  typedef struct {
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic               sat;
  } estimate_t;

  longint unsigned dt_reg, rn_reg, qn_reg;
  longint pos_q, vel_q;
  longint cov[4];
  bit clamped;
  int errors;
  estimate_t pending[$];

  function new();
    dt_reg = 328;
    rn_reg = 196608;
    qn_reg = 458752;
    pos_q = 0;
    vel_q = 0;
    foreach (cov[i]) cov[i] = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      kpv_pkg::CFG_TIME_STEP:     dt_reg = val[15:0];
      kpv_pkg::CFG_MEASURE_NOISE: rn_reg = val[30:0];
      kpv_pkg::CFG_PROCESS_NOISE: qn_reg = val[30:0];
      default: ;
    endcase
  endfunction

  function longint sat32(longint v);
    if (v > 64'sd2147483647) begin
      clamped = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clamped = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Product of two words, floored after the fraction shift (fits in 64 bits).
  function longint qmul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(a) * 128'(b);
    p = p >>> 16;
    if (p > 128'sd2147483647) begin
      clamped = 1;
      return 64'sd2147483647;
    end
    if (p < -128'sd2147483648) begin
      clamped = 1;
      return -64'sd2147483648;
    end
    return longint'(p);
  endfunction

  // Quotient in Q16.16, truncated toward zero; divide by zero saturates.
  function longint qdiv(longint n, longint d);
    logic signed [127:0] q;
    if (d == 0) begin
      if (n == 0) return 0;
      clamped = 1;
      return n > 0 ? 64'sd2147483647 : -64'sd2147483648;
    end
    q = (128'(n) <<< 16) / 128'(d);
    if (q > 128'sd2147483647) begin
      clamped = 1;
      return 64'sd2147483647;
    end
    if (q < -128'sd2147483648) begin
      clamped = 1;
      return -64'sd2147483648;
    end
    return longint'(q);
  endfunction

  // Note an accepted input item and queue the estimate it should produce.
  function void note_item(logic signed [31:0] acc_in, logic signed [31:0] z_in);
    longint acc, z, dt, rn, qn, hdt2, x0, x1, res, s, t00, t01, k0, k1;
    longint a00, a10, u00, p00, p01, p10, p11;
    estimate_t e;
    clamped = 0;
    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    acc = acc_in;
    z = z_in;
    dt = sat32(longint'(dt_reg));
    rn = sat32(longint'(rn_reg));
    qn = sat32(longint'(qn_reg));
    hdt2 = qmul(dt, dt) / 2;
    x0 = sat32(sat32(pos_q + qmul(dt, vel_q)) + qmul(hdt2, acc));
    x1 = sat32(vel_q + qmul(dt, acc));
    res = sat32(z - x0);
    s = sat32(p00 + rn);
    t00 = sat32(p00 + qmul(dt, p10));
    t01 = sat32(p01 + qmul(dt, p11));
    k0 = qdiv(t00, s);
    k1 = qdiv(p10, s);
    pos_q = sat32(x0 + qmul(res, k0));
    vel_q = sat32(x1 + qmul(res, k1));
    a00 = sat32(t00 + qmul(t01, dt));
    a10 = sat32(p10 + qmul(p11, dt));
    u00 = sat32(p00 + qmul(p01, dt));
    cov[0] = sat32(sat32(a00 - qmul(k0, u00)) + qn);
    cov[1] = sat32(t01 - qmul(k0, p01));
    cov[2] = sat32(a10 - qmul(k1, u00));
    cov[3] = sat32(sat32(p11 - qmul(k1, p01)) + qn);
    e.pos = pos_q[31:0];
    e.vel = vel_q[31:0];
    e.sat = clamped;
    pending.push_back(e);
  endfunction

  function void check_result(logic [63:0] data, logic sat);
    estimate_t e;
    if (pending.size() == 0) begin
      $error("unexpected estimate %h", data);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (data[31:0] !== e.pos) begin
      $error("position_est expected %h got %h", e.pos, data[31:0]);
      errors++;
    end
    if (data[63:32] !== e.vel) begin
      $error("velocity_est expected %h got %h", e.vel, data[63:32]);
      errors++;
    end
    if (sat !== e.sat) begin
      $error("saturated expected %b got %b", e.sat, sat);
      errors++;
    end
  endfunction
endclass

module kalman_position_velocity_step_top_tb;
  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  kalman_scoreboard sb = new();
  int idle_cycles = 0;
  bit out_stall_off = 0;

  always #5 clk = ~clk;

  kalman_position_velocity_step_top u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // Result side: check accepted items, random stalls between them
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (rst_n && !out_tready) begin
        gap = out_stall_off ? 0 : $urandom_range(0, 5);
        repeat (gap) @(negedge clk);
        out_tready <= 1'b1;
      end else if (out_tready && out_tvalid) begin
        if (!out_stall_off && $urandom_range(0, 1)) out_tready <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no handshake on the input, output or config channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("kalman_position_velocity_step_top verification failed");
      $finish;
    end
  end

  // valid drops at one falling edge and may rise again at the next one
  task automatic send_item(logic [31:0] acc, logic [31:0] z);
    @(negedge clk);
    repeat ($urandom_range(0, 5)) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {z, acc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(acc, z);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0003_FFFF);
      3: return -$urandom_range(0, 32'h0003_FFFF);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(int n, bit tame);
    for (int i = 0; i < n; i++) begin
      if (tame) send_item($signed(rand_word()) >>> 8, $urandom_range(0, 32'h00FF_FFFF));
      else send_item(rand_word(), rand_word());
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: field extremes, zero measurement, reset registers
    send_item(32'h0, 32'h0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000);
    send_item(32'hFFFF_FFFF, 32'h0001_0000);
    send_item(32'h0001_0000, 32'hFFFF_0000);
    send_item(32'h5555_5555, 32'hAAAA_AAAA);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);
    drain();
    // Zero process noise with smallest R and time step, then out-of-list index
    write_cfg(kpv_pkg::CFG_PROCESS_NOISE, 32'h0);
    write_cfg(kpv_pkg::CFG_MEASURE_NOISE, 32'h1);
    write_cfg(kpv_pkg::CFG_TIME_STEP, 32'h1);
    write_cfg(2'd3, 32'hFFFF_FFFF);
    send_item(32'h0, 32'h0);
    send_item(32'h0001_0000, 32'h0002_0000);
    send_item(32'h8000_0000, 32'h7FFF_FFFF);
    drain();
    // Largest register values (upper bits must be masked)
    write_cfg(kpv_pkg::CFG_TIME_STEP, 32'hFFFF_FFFF);
    write_cfg(kpv_pkg::CFG_MEASURE_NOISE, 32'hFFFF_FFFF);
    write_cfg(kpv_pkg::CFG_PROCESS_NOISE, 32'hFFFF_FFFF);
    run_phase(8, 0);
    drain();

    // Random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(kpv_pkg::CFG_TIME_STEP, $urandom_range(1, 16'hFFFF));
      write_cfg(kpv_pkg::CFG_MEASURE_NOISE,
                (ph == 3) ? 32'h1 : {1'b0, 31'($urandom)} | 1);
      write_cfg(kpv_pkg::CFG_PROCESS_NOISE,
                (ph == 5) ? 32'h0 : $urandom_range(0, 32'h00FF_FFFF));
      out_stall_off = (ph == 6);
      run_phase(35, 1);
      run_phase(12, 0);
      drain();
    end
    out_stall_off = 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("kalman_position_velocity_step_top verification clean");
    else
      $display("kalman_position_velocity_step_top verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+rtl
rtl/kpv_pkg.sv
rtl/kpv_alu.sv
rtl/kpv_seq.sv
rtl/kalman_position_velocity_step_top.sv
rtl/kpv_checker.sv
tb/kalman_position_velocity_step_top_tb.sv
